// File: rtl/ilt_pkg.sv
// Shared types, codes and helpers for the INI line tokenizer.
package ilt_pkg;

  // Field widths of the stream beats
  localparam int unsigned TEXT_W      = 8;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned START_W     = 32;
  localparam int unsigned LENGTH_W    = 16;
  localparam int unsigned OUT_DATA_W  = START_W + LENGTH_W;

  // Parameter defaults
  localparam int unsigned DEF_POSITION_BITS = 32;
  localparam int unsigned DEF_LENGTH_BITS   = 16;

  // Parse modes
  localparam int unsigned MODE_W = 3;
  localparam logic [MODE_W-1:0] MODE_IDLE     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SECTION  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_COMMENT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_KEY      = 3'd3;
  localparam logic [MODE_W-1:0] MODE_VALSTART = 3'd4;
  localparam logic [MODE_W-1:0] MODE_VALUE    = 3'd5;

  // Token kinds
  localparam logic [KIND_W-1:0] KIND_SECTION = 2'd0;
  localparam logic [KIND_W-1:0] KIND_KEY     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_VALUE   = 2'd2;

  // Characters of interest
  localparam logic [TEXT_W-1:0] CH_LBRACKET = 8'h5B;
  localparam logic [TEXT_W-1:0] CH_SEMI     = 8'h3B;
  localparam logic [TEXT_W-1:0] CH_EQUALS   = 8'h3D;
  localparam logic [TEXT_W-1:0] CH_NEWLINE  = 8'h0A;

  // Input beat held in the input register
  typedef struct packed {
    logic              vld;
    logic [TEXT_W-1:0] data;
  } text_beat_t;

  // Token produced by the parse core
  typedef struct packed {
    logic                vld;
    logic [KIND_W-1:0]   kind;
    logic [START_W-1:0]  start;
    logic [LENGTH_W-1:0] length;
  } token_t;

  // 0-9, a-z, A-Z
  function automatic logic is_alnum(input logic [TEXT_W-1:0] b);
    return ((b >= 8'h30) && (b <= 8'h39)) ||
           ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A));
  endfunction

endpackage

// File: rtl/ilt_in_stage.sv
// Input register of the INI line tokenizer.
module ilt_in_stage (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [ilt_pkg::TEXT_W-1:0]  in_tdata,   // [7:0] text_byte
  input  logic                        out_free,
  output ilt_pkg::text_beat_t         beat
);
  import ilt_pkg::*;

  logic              vld_r;
  logic [TEXT_W-1:0] data_r;

  // Take a new beat when empty or when the held one moves on
  assign in_tready = !vld_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_tready) begin
      vld_r <= in_tvalid;
    end
  end

  // Payload needs no reset
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      data_r <= in_tdata;
    end
  end

  assign beat.vld  = vld_r;
  assign beat.data = data_r;

endmodule

// File: rtl/ilt_parse_core.sv
// Parse mode, byte offset and token start, with the per-byte decode.
module ilt_parse_core #(
  parameter int unsigned POSITION_BITS = ilt_pkg::DEF_POSITION_BITS,
  parameter int unsigned LENGTH_BITS   = ilt_pkg::DEF_LENGTH_BITS
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ilt_pkg::text_beat_t beat,
  input  logic                step,
  output ilt_pkg::token_t     token
);
  import ilt_pkg::*;

  localparam int unsigned CMP_W = (POSITION_BITS > LENGTH_BITS) ? POSITION_BITS : LENGTH_BITS;

  logic [MODE_W-1:0]        mode_r, mode_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] begin_r, begin_nxt;

  logic [POSITION_BITS-1:0] span, sec_len, raw_len, tok_start;
  logic [CMP_W-1:0]         len_ext, len_max, len_sat;
  logic                     emit;
  logic [KIND_W-1:0]        kind;
  logic [TEXT_W-1:0]        b;

  assign b        = beat.data;
  assign span     = pos_r - begin_r;
  assign sec_len  = (span < POSITION_BITS'(2)) ? '0 : span - POSITION_BITS'(2);
  assign pos_nxt  = pos_r + POSITION_BITS'(1);

  // Mode transitions and token events
  always_comb begin
    mode_nxt  = mode_r;
    begin_nxt = begin_r;
    emit      = 1'b0;
    kind      = KIND_VALUE;
    raw_len   = span;
    tok_start = begin_r;
    unique case (mode_r)
      MODE_SECTION: begin
        if (b == CH_NEWLINE) begin
          emit      = 1'b1;
          kind      = KIND_SECTION;
          raw_len   = sec_len;
          tok_start = begin_r + POSITION_BITS'(1);
          mode_nxt  = MODE_IDLE;
        end
      end
      MODE_COMMENT: begin
        if (b == CH_NEWLINE) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_KEY: begin
        if (b == CH_EQUALS) begin
          emit      = 1'b1;
          kind      = KIND_KEY;
          begin_nxt = pos_nxt;
          mode_nxt  = MODE_VALSTART;
        end
      end
      MODE_VALSTART: begin
        priority if (b == CH_LBRACKET) begin
          begin_nxt = pos_r;
          mode_nxt  = MODE_SECTION;
        end else if (b == CH_SEMI) begin
          mode_nxt = MODE_COMMENT;
        end else if (b == CH_NEWLINE) begin
          emit     = 1'b1;
          mode_nxt = MODE_IDLE;
        end else begin
          mode_nxt = MODE_VALUE;
        end
      end
      MODE_VALUE: begin
        if (b == CH_NEWLINE) begin
          emit     = 1'b1;
          mode_nxt = MODE_IDLE;
        end
      end
      default: begin
        // idle, and any unused code
        priority if (b == CH_LBRACKET) begin
          begin_nxt = pos_r;
          mode_nxt  = MODE_SECTION;
        end else if (b == CH_SEMI) begin
          mode_nxt = MODE_COMMENT;
        end else if (is_alnum(b)) begin
          begin_nxt = pos_r;
          mode_nxt  = MODE_KEY;
        end else begin
          mode_nxt = MODE_IDLE;
        end
      end
    endcase
  end

  // Length saturation
  assign len_ext = CMP_W'(raw_len);
  assign len_max = CMP_W'({LENGTH_BITS{1'b1}});
  assign len_sat = (len_ext > len_max) ? len_max : len_ext;

  assign token.vld    = step && emit;
  assign token.kind   = kind;
  assign token.start  = START_W'(tok_start);
  assign token.length = LENGTH_W'(len_sat);

  // State update, one byte per step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      pos_r   <= '0;
      begin_r <= '0;
    end else if (step) begin
      mode_r  <= mode_nxt;
      pos_r   <= pos_nxt;
      begin_r <= begin_nxt;
    end
  end

`ifndef SYNTHESIS
  // Offset advances by one for each consumed byte
  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    step |=> (pos_r == $past(pos_r) + POSITION_BITS'(1)))
    else $error("byte offset did not advance");

  // A key closed by '=' enters the value-start mode
  a_key_close: assert property (@(posedge clk) disable iff (!rst_n)
    (step && (mode_r == MODE_KEY) && (b == CH_EQUALS)) |=> (mode_r == MODE_VALSTART))
    else $error("key end did not enter value start");

  // Only the six defined modes are ever entered
  a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r <= MODE_VALUE)
    else $error("parse mode out of range");
`endif

endmodule

// File: rtl/ilt_out_stage.sv
// Result register of the INI line tokenizer.
module ilt_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ilt_pkg::token_t                 token,
  output logic                            out_free,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ilt_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] token_start, [47:32] token_length
  output logic [ilt_pkg::KIND_W-1:0]      out_tuser   // [1:0] token_kind
);
  import ilt_pkg::*;

  logic                  vld_r;
  logic [KIND_W-1:0]     kind_r;
  logic [START_W-1:0]    start_r;
  logic [LENGTH_W-1:0]   length_r;

  // Register can load when empty or being drained
  assign out_free = !vld_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (out_free) begin
      vld_r <= token.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && token.vld) begin
      kind_r   <= token.kind;
      start_r  <= token.start;
      length_r <= token.length;
    end
  end

  assign out_tvalid = vld_r;
  assign out_tdata  = {length_r, start_r};
  assign out_tuser  = kind_r;

endmodule

// File: rtl/ini_line_tokenizer_unit.sv
// INI line tokenizer: one text byte in per beat, section/key/value tokens out.
// A token is loaded into the result register when the byte that closes it is parsed from the input register.
// Throughput: one byte per cycle while the result register is free, set by the mode/offset update in the parse core.
// While a finished token waits for out_tready, one more byte is held and the input then stalls.
// Reset (rst_n low, synchronous) clears the mode to idle, offset and token start to zero,
// and empties both registers; a pending token is never flushed.
module ini_line_tokenizer_unit #(
  parameter int unsigned POSITION_BITS = ilt_pkg::DEF_POSITION_BITS,
  parameter int unsigned LENGTH_BITS   = ilt_pkg::DEF_LENGTH_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [ilt_pkg::TEXT_W-1:0]      in_tdata,   // [7:0] text_byte
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [ilt_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] token_start, [47:32] token_length
  output logic [ilt_pkg::KIND_W-1:0]      out_tuser   // [1:0] token_kind
);
  import ilt_pkg::*;

  text_beat_t beat;
  token_t     token;
  logic       out_free;
  logic       step;

  // A held byte is parsed when the result register can take its outcome
  assign step = beat.vld && out_free;

  ilt_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_free  (out_free),
    .beat      (beat)
  );

  ilt_parse_core #(
    .POSITION_BITS (POSITION_BITS),
    .LENGTH_BITS   (LENGTH_BITS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .beat  (beat),
    .step  (step),
    .token (token)
  );

  ilt_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .token      (token),
    .out_free   (out_free),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

`ifndef SYNTHESIS
  // With the result stalled, a full input register refuses new beats
  a_stall_block: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready && beat.vld) |-> !in_tready)
    else $error("input taken over a stalled full pipeline");

  // No token straight after reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // A token only comes from a parsed byte
  a_token_src: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !$past(out_tvalid)) |-> $past(step))
    else $error("token without a parsed byte");
`endif

endmodule
